// ===== rtl/gregorian_date_add_days_assert.svh =====
// Assertion macros for the date adder.
`ifndef GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GDAD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("date adder check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define GDAD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("date adder sequencing check failed");

`endif

// ===== rtl/gdad_pkg.sv =====
// Package: widths, calendar constants and month length lookup for the date adder.
`timescale 1ns / 1ps
`default_nettype none
package gdad_pkg;

	localparam int YEAR_W  = 16;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int SUM_W   = 17;
	localparam int REM_W   = 9;

	localparam logic [YEAR_W-1:0]  YEAR_MAX  = 16'hFFFF;
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;
	localparam logic [DAY_W-1:0]   DAY_FEB_LEAP = 5'd29;

	localparam logic [REM_W-1:0] REM400_DIV  = 9'd400 - 9'd0;
	localparam logic [REM_W-1:0] REM400_LAST = 9'd399;
	localparam logic [REM_W-1:0] REM400_100  = 9'd100;
	localparam logic [REM_W-1:0] REM400_200  = 9'd200;
	localparam logic [REM_W-1:0] REM400_300  = 9'd300;

	typedef logic [DAY_W-1:0] month_len_tab_t [12];

	localparam month_len_tab_t MONTH_LEN = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
	                                                input logic leap);
		logic [MONTH_W-1:0] idx;
		idx = m - MONTH_JAN;
		if (m == MONTH_FEB && leap)
			return DAY_FEB_LEAP;
		else if (m >= MONTH_JAN && m <= MONTH_DEC)
			return MONTH_LEN[idx];
		else
			return DAY_LAST_DEC;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/gdad_rem400.sv =====
// Remainder of a year by 400 through a reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none
module gdad_rem400 (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire logic [gdad_pkg::YEAR_W-1:0] dividend,
	output logic                             busy,
	output logic [gdad_pkg::REM_W-1:0]       rem
);
	import gdad_pkg::*;

	localparam int CNT_W  = 2;
	localparam int PROD_W = 23;
	localparam int QUO_W  = 8;
	localparam logic [CNT_W-1:0]  STEPS    = 2'd2;
	localparam logic [CNT_W-1:0]  STEP_QUO = 2'd2;
	localparam logic [PROD_W-1:0] RECIP_25 = 23'd1311;

	logic [CNT_W-1:0]  cnt_q;
	logic [YEAR_W-1:0] year_q;
	logic [QUO_W-1:0]  quo_q;
	logic [REM_W-1:0]  rem_q;
	logic [PROD_W-1:0] prod;
	logic [YEAR_W-1:0] back;
	logic [YEAR_W-1:0] diff;

	// year / 400 = (year >> 4) / 25, taken as (year >> 4) * 1311 >> 15
	assign prod = PROD_W'(year_q[YEAR_W-1:4]) * RECIP_25;
	assign back = YEAR_W'(quo_q) * YEAR_W'(REM400_DIV);
	assign diff = year_q - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= STEPS;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			year_q <= dividend;
		end else if (cnt_q == STEP_QUO) begin
			quo_q <= prod[PROD_W-1 -: QUO_W];
		end else if (cnt_q != '0) begin
			rem_q <= diff[REM_W-1:0];
		end
	end

	assign busy = (cnt_q != '0);
	assign rem  = rem_q;

endmodule
`default_nettype wire

// ===== rtl/gregorian_date_add_days.sv =====
// Top level: Gregorian date plus a day count, walked one month per cycle.
//
// Raise start with a date and a day count while busy is low; the item is taken on
// that edge and busy stays high until the result appears. The result is shown for
// exactly one cycle with done high and must be captured then: there is no way to
// hold it off. An item first gets the year modulo 400 from the remainder unit,
// then checks the date; the shared subtract-and-compare unit then steps one
// month per cycle and settles the day once the remaining count fits the month.
// An invalid date comes back from the check state without walking. busy is low
// while done is high, so the next item can be taken at the edge that ends the
// result cycle.
// An invalid date comes back unchanged with date_valid low; a walk past December
// of year 65535 stops at 65535-12-31 with year_overflow high.
`timescale 1ns / 1ps
`default_nettype none
`include "gregorian_date_add_days_assert.svh"
module gregorian_date_add_days (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] start_year,
	input  wire logic [3:0]  start_month,
	input  wire logic [4:0]  start_day,
	input  wire logic [15:0] add_days,
	output logic             done,
	output logic [15:0]      end_year,
	output logic [3:0]       end_month,
	output logic [4:0]       end_day,
	output logic             date_valid,
	output logic             year_overflow
);
	import gdad_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REM,
		ST_CHECK,
		ST_WALK
	} state_t;

	state_t             state_q;
	logic               done_q;
	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] month_q;
	logic [DAY_W-1:0]   day_q;
	logic [SUM_W-1:0]   sum_q;
	logic [REM_W-1:0]   r400_q;
	logic [YEAR_W-1:0]  end_year_q;
	logic [MONTH_W-1:0] end_month_q;
	logic [DAY_W-1:0]   end_day_q;
	logic               valid_q;
	logic               ovf_q;

	logic               accept;
	logic               rem_busy;
	logic [REM_W-1:0]   rem_out;
	logic               cent;
	logic               leap;
	logic [DAY_W-1:0]   mlen;
	logic [SUM_W-1:0]   mlen_ext;
	logic               bad_date;

	assign accept = start && (state_q == ST_IDLE);

	gdad_rem400 u_rem400 (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.dividend (start_year),
		.busy     (rem_busy),
		.rem      (rem_out)
	);

	assign cent = (r400_q == '0) || (r400_q == REM400_100) ||
	              (r400_q == REM400_200) || (r400_q == REM400_300);
	assign leap     = (year_q[1:0] == 2'b00) && (!cent || (r400_q == '0));
	assign mlen     = month_days(month_q, leap);
	assign mlen_ext = SUM_W'(mlen);
	assign bad_date = (month_q < MONTH_JAN) || (month_q > MONTH_DEC) ||
	                  (day_q == '0) || (day_q > mlen);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_REM;
				end
				ST_REM: begin
					if (!rem_busy)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (bad_date) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (sum_q <= mlen_ext ||
					    (month_q == MONTH_DEC && year_q == YEAR_MAX)) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					year_q  <= start_year;
					month_q <= start_month;
					day_q   <= start_day;
					sum_q   <= SUM_W'(start_day) + SUM_W'(add_days);
				end
			end
			ST_REM: begin
				r400_q <= rem_out;
			end
			ST_CHECK: begin
				if (bad_date) begin
					end_year_q  <= year_q;
					end_month_q <= month_q;
					end_day_q   <= day_q;
					valid_q     <= 1'b0;
					ovf_q       <= 1'b0;
				end
			end
			ST_WALK: begin
				if (sum_q <= mlen_ext) begin
					end_year_q  <= year_q;
					end_month_q <= month_q;
					end_day_q   <= sum_q[DAY_W-1:0];
					valid_q     <= 1'b1;
					ovf_q       <= 1'b0;
				end else if (month_q == MONTH_DEC) begin
					if (year_q == YEAR_MAX) begin
						end_year_q  <= year_q;
						end_month_q <= month_q;
						end_day_q   <= DAY_LAST_DEC;
						valid_q     <= 1'b1;
						ovf_q       <= 1'b1;
					end else begin
						sum_q   <= sum_q - mlen_ext;
						year_q  <= year_q + YEAR_W'(1);
						month_q <= MONTH_JAN;
						r400_q  <= (r400_q == REM400_LAST) ? '0 : r400_q + REM_W'(1);
					end
				end else begin
					sum_q   <= sum_q - mlen_ext;
					month_q <= month_q + MONTH_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign end_year      = end_year_q;
	assign end_month     = end_month_q;
	assign end_day       = end_day_q;
	assign date_valid    = valid_q;
	assign year_overflow = ovf_q;

	`GDAD_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
	`GDAD_ASSERT_NOW(a_done_idle, done, !busy)
	`GDAD_ASSERT_NOW(a_valid_range, done && date_valid,
		end_day != 5'd0 && end_month >= MONTH_JAN && end_month <= MONTH_DEC)
	`GDAD_ASSERT_NOW(a_ovf_sat, done && year_overflow,
		date_valid && end_year == YEAR_MAX && end_month == MONTH_DEC && end_day == DAY_LAST_DEC)

endmodule
`default_nettype wire
